// ----- design/qhc_pkg.sv -----
// Shared types, constants and index function for the quadgram histogram block.
package qhc_pkg;

    localparam int SYMBOLS          = 27;
    localparam int TERM             = 26;
    localparam int TABLE_SIZE       = SYMBOLS * SYMBOLS * SYMBOLS * SYMBOLS;
    localparam int ADDR_W           = $clog2(TABLE_SIZE);
    localparam int SYM_W            = 5;
    localparam int FRAC_W           = 17;
    localparam int WEIGHT_W         = 16;
    localparam int DEF_COUNT_WIDTH  = 32;
    localparam int DIV_STEPS        = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    typedef enum logic [1:0] {
        AM_LETTER,
        AM_TERM,
        AM_QUERY
    } t_amode;

    typedef struct packed {
        logic              latch;
        t_amode            amode;
        logic              rd;
        logic              wr;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
        logic              push_letter;
        logic              ctx_reset;
        logic              sum_clr;
        logic              sum_acc;
        logic              div_load;
        logic              div_step;
        logic              div_first;
        logic              emit;
        logic              emit_unseen;
        logic [SYM_W-1:0]  sym;
    } t_cmd;

    typedef struct packed {
        logic opcode;
        logic is_letter;
        logic eot;
        logic in_word;
        logic q_valid;
        logic sum_zero;
    } t_stat;

    // ((a*27 + b)*27 + c)*27 + d
    function automatic logic [ADDR_W-1:0] idx(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b,
                                              input logic [SYM_W-1:0] c,
                                              input logic [SYM_W-1:0] d);
        logic [ADDR_W-1:0] t;
        t = ADDR_W'(a) * ADDR_W'(SYMBOLS) + ADDR_W'(b);
        t = t * ADDR_W'(SYMBOLS) + ADDR_W'(c);
        t = t * ADDR_W'(SYMBOLS) + ADDR_W'(d);
        return t;
    endfunction

endpackage

// ----- design/qhc_ctrl.sv -----
// Sequencer: clearing pass, text read-modify-write, query sum/divide/emit.
module qhc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  qhc_pkg::t_stat i_stat,
    output qhc_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import qhc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_TXT_RD, S_TXT_WR, S_SUM, S_SUM_END,
        S_CHECK, S_Q_RD, S_Q_LOAD, S_Q_DIV, S_Q_EMIT, S_UNSEEN
    } t_state;

    localparam int CNT_W = $clog2(DIV_STEPS);

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [SYM_W-1:0]  r_sym;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_term;
    logic              r_pend;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.amode    = AM_QUERY;
        o_cmd.sym      = r_sym;
        o_cmd.clr_addr = r_clr;
        case (r_state)
            S_CLEAR:  o_cmd.clr_we = 1'b1;
            S_IDLE:   o_cmd.latch  = i_start;
            S_DECIDE: o_cmd.sum_clr = 1'b1;
            S_TXT_RD: begin
                o_cmd.rd    = 1'b1;
                o_cmd.amode = r_term ? AM_TERM : AM_LETTER;
            end
            S_TXT_WR: begin
                o_cmd.wr          = 1'b1;
                o_cmd.ctx_reset   = r_term;
                o_cmd.push_letter = !r_term;
            end
            S_SUM: begin
                o_cmd.rd      = 1'b1;
                o_cmd.sum_acc = r_pend;
            end
            S_SUM_END: o_cmd.sum_acc = 1'b1;
            S_Q_RD:    o_cmd.rd = 1'b1;
            S_Q_LOAD:  o_cmd.div_load = 1'b1;
            S_Q_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
            end
            S_Q_EMIT:  o_cmd.emit = 1'b1;
            S_UNSEEN:  o_cmd.emit_unseen = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_sym   <= '0;
            r_cnt   <= '0;
            r_term  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(TABLE_SIZE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_sym  <= '0;
                    r_pend <= 1'b0;
                    if (!i_stat.opcode) begin
                        if (i_stat.is_letter) begin
                            r_term  <= 1'b0;
                            r_state <= S_TXT_RD;
                        end else if (i_stat.in_word) begin
                            r_term  <= 1'b1;
                            r_state <= S_TXT_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (!i_stat.q_valid) begin
                        r_state <= S_UNSEEN;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_TXT_RD: r_state <= S_TXT_WR;
                S_TXT_WR: begin
                    // end of text closes the word just extended
                    if (!r_term && i_stat.eot) begin
                        r_term  <= 1'b1;
                        r_state <= S_TXT_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    r_pend <= 1'b1;
                    if (r_sym == SYM_W'(TERM)) r_state <= S_SUM_END;
                    else r_sym <= r_sym + 1'b1;
                end
                S_SUM_END: r_state <= S_CHECK;
                S_CHECK: begin
                    r_sym   <= '0;
                    r_state <= i_stat.sum_zero ? S_UNSEEN : S_Q_RD;
                end
                S_Q_RD:   r_state <= S_Q_LOAD;
                S_Q_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_Q_EMIT;
                end
                S_Q_EMIT: begin
                    if (r_sym == SYM_W'(TERM)) r_state <= S_IDLE;
                    else begin
                        r_sym   <= r_sym + 1'b1;
                        r_state <= S_Q_RD;
                    end
                end
                S_UNSEEN: begin
                    if (r_sym == SYM_W'(TERM)) r_state <= S_IDLE;
                    else r_sym <= r_sym + 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/qhc_dp.sv -----
// Datapath: count memory, context, weight register, accumulators, divider, result regs.
module qhc_dp #(
    parameter int COUNT_WIDTH = qhc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qhc_pkg::t_cmd                i_cmd,
    output qhc_pkg::t_stat               o_stat,
    input  logic                         i_cfg_wr_en,
    input  logic [qhc_pkg::WEIGHT_W-1:0] i_cfg_wr_data,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_end_of_text,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_first,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_second,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_third,
    output logic                         o_result_valid,
    output logic [qhc_pkg::SYM_W-1:0]    o_symbol,
    output logic [qhc_pkg::FRAC_W-1:0]   o_cumulative_fraction,
    output logic                         o_last
);
    import qhc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 5;

    logic [COUNT_WIDTH-1:0] mem [TABLE_SIZE];

    logic                   r_opcode, r_eot;
    logic [7:0]             r_byte;
    logic [SYM_W-1:0]       r_qa, r_qb, r_qc;
    logic [SYM_W-1:0]       r_ctx_o, r_ctx_m, r_ctx_n;
    logic                   r_in_word;
    logic [WEIGHT_W-1:0]    r_weight;
    logic [ADDR_W-1:0]      r_raddr;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [SUM_W-1:0]       r_sum, r_cum;
    logic [SUM_W:0]         r_rem;
    logic [FRAC_W-1:0]      r_quo;

    logic                   is_letter;
    logic [SYM_W-1:0]       letter;
    logic [ADDR_W-1:0]      addr;
    logic [COUNT_WIDTH:0]   sat_sum;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [SUM_W-1:0]       cum_next;
    logic [SUM_W:0]         rr;
    logic                   ge;

    assign is_letter = (r_byte >= 8'h61) && (r_byte <= 8'h7a);
    assign letter    = SYM_W'(r_byte - 8'h61);

    always_comb begin
        case (i_cmd.amode)
            AM_LETTER: addr = idx(r_ctx_o, r_ctx_m, r_ctx_n, letter);
            AM_TERM:   addr = idx(r_ctx_o, r_ctx_m, r_ctx_n, SYM_W'(TERM));
            AM_QUERY:  addr = idx(r_qa, r_qb, r_qc, i_cmd.sym);
            default:   addr = '0;
        endcase
    end

    assign sat_sum  = {1'b0, r_rdata} + (COUNT_WIDTH + 1)'(r_weight);
    assign wdata    = sat_sum[COUNT_WIDTH] ? '1 : sat_sum[COUNT_WIDTH-1:0];
    assign cum_next = r_cum + SUM_W'(r_rdata);

    // first quotient bit compares without a shift
    assign rr = i_cmd.div_first ? r_rem : {r_rem[SUM_W-1:0], 1'b0};
    assign ge = (rr >= {1'b0, r_sum});

    assign o_stat.opcode    = r_opcode;
    assign o_stat.is_letter = is_letter;
    assign o_stat.eot       = r_eot;
    assign o_stat.in_word   = r_in_word;
    assign o_stat.q_valid   = (r_qa < SYM_W'(SYMBOLS)) && (r_qb < SYM_W'(SYMBOLS))
                              && (r_qc < SYM_W'(SYMBOLS));
    assign o_stat.sum_zero  = (r_sum == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) mem[i_cmd.clr_addr] <= '0;
        else if (i_cmd.wr) mem[r_raddr] <= wdata;
        if (i_cmd.rd) begin
            r_raddr <= addr;
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_byte   <= i_text_byte;
            r_eot    <= i_end_of_text;
            r_qa     <= i_query_first;
            r_qb     <= i_query_second;
            r_qc     <= i_query_third;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
            r_cum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= r_sum + SUM_W'(r_rdata);
        end else if (i_cmd.div_load) begin
            r_cum <= cum_next;
        end
        if (i_cmd.div_load) begin
            r_rem <= {1'b0, cum_next};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? (rr - {1'b0, r_sum}) : rr;
            r_quo <= {r_quo[FRAC_W-2:0], ge};
        end
        if (i_cmd.emit || i_cmd.emit_unseen) begin
            o_symbol <= i_cmd.sym;
            o_last   <= (i_cmd.sym == SYM_W'(TERM));
        end
        if (i_cmd.emit) o_cumulative_fraction <= r_quo;
        else if (i_cmd.emit_unseen)
            o_cumulative_fraction <= (i_cmd.sym == SYM_W'(TERM)) ? {1'b1, 16'd0} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_o        <= SYM_W'(TERM);
            r_ctx_m        <= SYM_W'(TERM);
            r_ctx_n        <= SYM_W'(TERM);
            r_in_word      <= 1'b0;
            r_weight       <= WEIGHT_RESET;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit || i_cmd.emit_unseen;
            if (i_cfg_wr_en) r_weight <= i_cfg_wr_data;
            if (i_cmd.ctx_reset) begin
                r_ctx_o   <= SYM_W'(TERM);
                r_ctx_m   <= SYM_W'(TERM);
                r_ctx_n   <= SYM_W'(TERM);
                r_in_word <= 1'b0;
            end else if (i_cmd.push_letter) begin
                r_ctx_o   <= r_ctx_m;
                r_ctx_m   <= r_ctx_n;
                r_ctx_n   <= letter;
                r_in_word <= 1'b1;
            end
        end
    end

endmodule

// ----- design/quadgram_histogram_cdf_top.sv -----
// Top level: order-4 character histogram with per-context cumulative query.
//
//   channel   ports                                         handshake
//   command   i_opcode i_text_byte i_end_of_text i_query_*  i_start & !o_busy
//   result    o_symbol o_cumulative_fraction o_last         o_result_valid, one cycle
//   config    i_cfg_wr_data (word_weight)                   i_cfg_wr_en
//
// After reset the count memory is cleared one entry a cycle; o_busy stays high until all 531441 entries are clear.
// Text byte: a decode state, then a read state and a write state per counter read-modify-write (letter, word end).
// Query: decode, sum 27 counts and check the sum, then per symbol read, load,
// 17-step restoring divide and emit; an unseen context emits one result a cycle.
// The single-port count memory and the bit-serial divider set this sequence.
// Results cannot be stalled; the next command is taken once o_busy falls.
module quadgram_histogram_cdf_top #(
    parameter int COUNT_WIDTH = qhc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_cfg_wr_en,
    input  logic [qhc_pkg::WEIGHT_W-1:0] i_cfg_wr_data,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_end_of_text,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_first,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_second,
    input  logic [qhc_pkg::SYM_W-1:0]    i_query_third,
    output logic                         o_result_valid,
    output logic [qhc_pkg::SYM_W-1:0]    o_symbol,
    output logic [qhc_pkg::FRAC_W-1:0]   o_cumulative_fraction,
    output logic                         o_last
);
    import qhc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    qhc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    qhc_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_wr_data         (i_cfg_wr_data),
        .i_opcode              (i_opcode),
        .i_text_byte           (i_text_byte),
        .i_end_of_text         (i_end_of_text),
        .i_query_first         (i_query_first),
        .i_query_second        (i_query_second),
        .i_query_third         (i_query_third),
        .o_result_valid        (o_result_valid),
        .o_symbol              (o_symbol),
        .o_cumulative_fraction (o_cumulative_fraction),
        .o_last                (o_last)
    );

endmodule
